### sv/rsti_pkg.sv
`default_nettype none
package rsti_pkg;

	localparam int MAX_RADIX  = 16;
	localparam int VALUE_BITS = 32;
	localparam int CHAR_W     = 8;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = $clog2(MAX_RADIX);
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

	localparam logic [RADIX_W-1:0]    RADIX_RESET      = 5'd10;
	localparam logic [CFG_DATA_W-1:0] ALPHA_LOW_RESET  = 64'd4050765991979987505;
	localparam logic [CFG_DATA_W-1:0] ALPHA_HIGH_RESET = 64'd14648;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	// back end operations
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_NEG   = 2'd1;
	localparam logic [1:0] OP_DIGIT = 2'd2;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int OUT_DEPTH = 2;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              end_of_text;
	} item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] number_value;
		logic                  alphabet_valid;
	} result_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [DIGIT_W-1:0] digit;
		logic [RADIX_W-1:0] radix;
		logic               last;
		logic               ok;
	} cmd_t;

endpackage
`default_nettype wire

### sv/rsti_front.sv
`default_nettype none
module rsti_front import rsti_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  take,
	input  wire item_t                 item,
	output      logic                  cmd_push,
	output      cmd_t                  cmd
);

	localparam logic [1:0] PH_SPACE = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [RADIX_W-1:0]      radix_q;
	logic [CFG_DATA_W-1:0]   alpha_lo_q;
	logic [CFG_DATA_W-1:0]   alpha_hi_q;
	logic [1:0]              phase_q;
	logic [1:0]              phase_n;
	logic [2*CFG_DATA_W-1:0] alpha_word;
	logic [CHAR_W-1:0]       alpha [MAX_RADIX];
	logic [RADIX_W-1:0]      n_used;
	logic [MAX_RADIX-1:0]    hit;
	logic [DIGIT_W-1:0]      digit;
	logic                    is_digit;
	logic                    is_space;
	logic                    is_sign;
	logic                    bad;
	logic                    ok;
	logic [1:0]              op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RESET;
			alpha_lo_q <= ALPHA_LOW_RESET;
			alpha_hi_q <= ALPHA_HIGH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RADIX_LENGTH:  radix_q    <= cfg_data[RADIX_W-1:0];
				CFG_ALPHABET_LOW:  alpha_lo_q <= cfg_data;
				CFG_ALPHABET_HIGH: alpha_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign alpha_word = {alpha_hi_q, alpha_lo_q};
	assign n_used     = (radix_q > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_q;

	// parallel match against every alphabet slot, lowest slot wins
	always_comb begin
		digit = '0;
		for (int i = 0; i < MAX_RADIX; i++) begin
			alpha[i] = alpha_word[i*CHAR_W +: CHAR_W];
			hit[i]   = (alpha[i] == item.text_char) && (RADIX_W'(i) < n_used);
		end
		for (int i = MAX_RADIX - 1; i >= 0; i--) begin
			if (hit[i])
				digit = DIGIT_W'(i);
		end
	end

	assign is_digit = |hit;
	assign is_space = (item.text_char inside {CH_TAB, CH_LF, CH_VT, CH_FF, CH_SPACE});
	assign is_sign  = (item.text_char inside {CH_PLUS, CH_MINUS});

	// radix range and alphabet check: forbidden characters and pairwise duplicates
	always_comb begin
		bad = (radix_q < RADIX_W'(2)) || (radix_q > RADIX_W'(MAX_RADIX));
		for (int a = 0; a < MAX_RADIX; a++) begin
			if (RADIX_W'(a) < n_used) begin
				if (alpha[a] inside {CH_NUL, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE,
						CH_PLUS, CH_MINUS})
					bad = 1'b1;
				for (int b = a + 1; b < MAX_RADIX; b++) begin
					if ((RADIX_W'(b) < n_used) && (alpha[b] == alpha[a]))
						bad = 1'b1;
				end
			end
		end
		ok = !bad;
	end

	always_comb begin
		op      = OP_NONE;
		phase_n = phase_q;
		if (phase_q == PH_SPACE && is_space) begin
			phase_n = PH_SPACE;
		end else if ((phase_q == PH_SPACE || phase_q == PH_SIGN) && is_sign) begin
			phase_n = PH_SIGN;
			if (item.text_char == CH_MINUS)
				op = OP_NEG;
		end else if (phase_q != PH_DONE && is_digit) begin
			phase_n = PH_DIGIT;
			op      = OP_DIGIT;
		end else begin
			phase_n = PH_DONE;
		end
		if (item.end_of_text)
			phase_n = PH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
		end else if (take) begin
			phase_q <= phase_n;
		end
	end

	// words with nothing to do are dropped here
	assign cmd_push  = take && (op != OP_NONE || item.end_of_text);
	assign cmd.op    = op;
	assign cmd.digit = digit;
	assign cmd.radix = radix_q;
	assign cmd.last  = item.end_of_text;
	assign cmd.ok    = ok;

endmodule
`default_nettype wire

### sv/rsti_cmd_queue.sv
`default_nettype none
module rsti_cmd_queue import rsti_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t din,
	output      logic full,
	input  wire logic rd,
	output      cmd_t dout,
	output      logic empty
);

	cmd_t                 slot_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### sv/rsti_back.sv
`default_nettype none
module rsti_back import rsti_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	input  wire cmd_t    cmd,
	output      logic    cmd_pop,
	output      result_t result,
	output      logic    empty,
	input  wire logic    pop
);

	logic [VALUE_BITS-1:0] acc_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] acc_n;
	logic                  neg_n;
	logic [VALUE_BITS-1:0] prod;
	logic                  v_s2;
	logic [VALUE_BITS-1:0] acc_s2;
	logic                  neg_s2;
	logic                  ok_s2;
	logic                  s2_adv;
	logic                  deq;
	result_t               res_s2;
	result_t               out_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  out_wr_q;
	logic [OUT_PTR_W-1:0]  out_rd_q;
	logic [OUT_PTR_W:0]    out_cnt_q;

	// stage 1: multiply-add or sign flip
	assign prod = acc_q * VALUE_BITS'(cmd.radix);

	always_comb begin
		acc_n = acc_q;
		neg_n = neg_q;
		case (cmd.op)
			OP_DIGIT: acc_n = prod + VALUE_BITS'(cmd.digit);
			OP_NEG:   neg_n = !neg_q;
			default: ;
		endcase
	end

	assign s2_adv  = v_s2 && (out_cnt_q != (OUT_PTR_W+1)'(OUT_DEPTH));
	assign cmd_pop = cmd_valid && (!cmd.last || !v_s2 || s2_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			neg_q <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cmd_pop) begin
				if (cmd.last) begin
					acc_q <= '0;
					neg_q <= 1'b0;
				end else begin
					acc_q <= acc_n;
					neg_q <= neg_n;
				end
			end
			if (cmd_pop && cmd.last)
				v_s2 <= 1'b1;
			else if (s2_adv)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.last) begin
			acc_s2 <= acc_n;
			neg_s2 <= neg_n;
			ok_s2  <= cmd.ok;
		end
	end

	// stage 2: apply sign, zero on a bad alphabet
	assign res_s2.number_value   = !ok_s2 ? '0 : (neg_s2 ? (~acc_s2 + 1'b1) : acc_s2);
	assign res_s2.alphabet_valid = ok_s2;

	assign deq    = pop && !empty;
	assign empty  = (out_cnt_q == '0);
	assign result = out_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (s2_adv)
			out_q[out_wr_q] <= res_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (s2_adv)
				out_wr_q <= out_wr_q + 1'b1;
			if (deq)
				out_rd_q <= out_rd_q + 1'b1;
			if (s2_adv && !deq)
				out_cnt_q <= out_cnt_q + 1'b1;
			else if (deq && !s2_adv)
				out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### sv/radix_string_to_integer.sv
`default_nettype none
// Channel   Handshake             Word                      Direction
// item      push / full           item_t   (char, last)     in
// result    empty / pop           result_t (value, valid)   out
// config    cfg_valid / cfg_ready cfg_index, cfg_data       in
//
// One character word a cycle while full is low; full rises only when the command
// queue between front and back holds four words.
// The last character's word passes the command queue, the multiply-add
// stage and the sign stage before its result enters the result queue.
// arst_n clears parser phase, accumulator, queues; config returns to radix
// ten with the reset alphabet, which repeats a character and so reads as
// invalid until rewritten. cfg_ready is always high.
// A stalled result side fills the two-word result queue, then the command
// queue, then raises full.
module radix_string_to_integer import rsti_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output      logic                  full,
	input  wire item_t                 item,
	output      logic                  empty,
	input  wire logic                  pop,
	output      result_t               result,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic take;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_empty;
	logic cmd_pop;

	// a word is taken whenever the command queue has room
	assign take = push && !full;

	// front: config registers, character classing, parse phase
	rsti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item      (item),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	// decoupling queue; carries the radix and alphabet check with each word
	rsti_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.din    (cmd_in),
		.full   (full),
		.rd     (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	// back: accumulator, sign, result queue
	rsti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire

### sv/rsti_checker.sv
`default_nettype none
module rsti_checker import rsti_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  push,
	input wire logic                  full,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire result_t               result
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not clear in reset");

	a_bad_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.alphabet_valid) |-> (result.number_value == '0))
		else $error("nonzero value with bad alphabet");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result changed");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without a word taken");

endmodule

bind radix_string_to_integer rsti_checker u_rsti_checker (.*);
`default_nettype wire
